// ===== rtl/fpr_pkg.sv =====
// fpr_pkg: shared types and constants for the ftp passive reply parser
// holds parse phase, number substate and radix enums, character codes and limits
// no dependencies
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int MAX_TEXT_BYTES = 63;
  localparam int BYTE_COUNT_W   = $clog2(MAX_TEXT_BYTES + 1);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_PORT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASV_CODE    = 1'b1;

  localparam logic [15:0] CONTROL_PORT_RST = 16'd21;
  localparam logic [9:0]  PASV_CODE_RST    = 10'd227;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // 2^63, the signed 64-bit limit in a 68-bit sum
  localparam logic [67:0] LIM63 = 68'h0_8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_STATUS,
    PH_SEEK_OPEN,
    PH_FIELD,
    PH_SEEK_COMMA,
    PH_SEEK_CLOSE,
    PH_FOUND,
    PH_STOPPED
  } phase_t;

  typedef enum logic [2:0] {
    NS_WS,
    NS_SIGN,
    NS_ZERO,
    NS_HEXPFX,
    NS_DIGITS
  } num_state_t;

  typedef enum logic [1:0] {
    RX_DEC,
    RX_OCT,
    RX_HEX
  } radix_t;

endpackage

// ===== rtl/ftp_pasv_reply_parser_unit.sv =====
// ftp_pasv_reply_parser_unit: passive mode reply parser, one payload byte per cycle
// while no final byte stalls; input register, single-pass parse, result register
// depends on fpr_pkg
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one payload byte of a segment per transaction, tlast on the
//   final byte; tdata = {segment_port, data_byte}. m_axis carries one result per
//   segment, sent for the transaction that had tlast set; tdata holds found,
//   pasv_address and data_port. Empty segments never appear on s_axis.
//   cfg_we/cfg_index/cfg_data write control_port (index 0) and pasv_code
//   (index 1); write only while no segment is in flight.
// Throughput: one byte per cycle unless a final byte waits on the result register;
//   the parse state (number substate, 64-bit magnitude with one shift-add and
//   compare) updates once per accepted byte.
// Result path: the input register loads the accepted tlast byte, then the result
//   register loads when that byte advances and holds m_axis_tvalid until taken.
// Reset: rst clears the parse state and both valid flags and restores the
//   registers to control_port 21 and pasv_code 227.
// Stall: while a result waits on m_axis, non-final bytes keep flowing; a final
//   byte holds in the input register until the result register frees up, and
//   s_axis_tready drops only then.
module ftp_pasv_reply_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] data_byte, [23:8] segment_port
  input  logic [fpr_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] found, [32:1] pasv_address, [48:33] data_port, [55:49] zero
  output logic [fpr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  input  logic                                 cfg_we,
  input  logic [fpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // configuration
  logic [15:0] control_port;
  logic [9:0]  pasv_code;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic [15:0] in_port;

  // parse state
  fpr_pkg::phase_t     phase, phase_next;
  fpr_pkg::num_state_t nsub, nsub_next;
  fpr_pkg::radix_t     radix, radix_next;
  logic [2:0]  field_index, field_index_next;
  logic        negative_flag, negative_flag_next;
  logic [63:0] magnitude, magnitude_next;
  logic        overflow_flag, overflow_flag_next;
  logic [fpr_pkg::BYTE_COUNT_W-1:0] byte_count, byte_count_next;
  logic [31:0] address_acc, address_acc_next;
  logic [15:0] port_acc, port_acc_next;
  logic [15:0] port_latch, port_latch_next;

  // result register
  logic        out_valid;
  logic        out_found;
  logic [31:0] out_address;
  logic [15:0] out_port;

  logic        advance;

  // character classes
  logic        is_ws, is_sign, is_dec, is_oct, is_hex, is_nz_dec;
  logic [3:0]  dval;

  // number take
  logic                tk_take, tk_acc, tk_neg;
  fpr_pkg::num_state_t tk_nsub;
  fpr_pkg::radix_t     tk_rx;
  logic [67:0] acc_scaled, acc_sum;
  logic        acc_ovf;
  logic [63:0] acc_mag;
  logic        acc_ovf_out;

  // number result
  logic        saturated, is_code;
  logic [7:0]  low_byte;

  fpr_pkg::phase_t ph;
  logic        srch;

  assign advance       = in_valid && (!in_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_comb begin
    is_ws     = (in_byte == fpr_pkg::CH_SPACE) ||
                (in_byte >= fpr_pkg::CH_TAB && in_byte <= fpr_pkg::CH_CR);
    is_sign   = (in_byte == fpr_pkg::CH_PLUS) || (in_byte == fpr_pkg::CH_MINUS);
    is_dec    = (in_byte >= fpr_pkg::CH_ZERO) && (in_byte <= fpr_pkg::CH_NINE);
    is_nz_dec = (in_byte >= fpr_pkg::CH_ONE) && (in_byte <= fpr_pkg::CH_NINE);
    is_oct    = (in_byte >= fpr_pkg::CH_ZERO) && (in_byte <= fpr_pkg::CH_SEVEN);
    is_hex    = is_dec ||
                (in_byte >= fpr_pkg::CH_LA && in_byte <= fpr_pkg::CH_LF) ||
                (in_byte >= fpr_pkg::CH_UA && in_byte <= fpr_pkg::CH_UF);
    if (is_dec) begin
      dval = 4'(in_byte - fpr_pkg::CH_ZERO);
    end else if (in_byte >= fpr_pkg::CH_LA && in_byte <= fpr_pkg::CH_LF) begin
      dval = 4'(in_byte - fpr_pkg::CH_LA + 8'd10);
    end else begin
      dval = 4'(in_byte - fpr_pkg::CH_UA + 8'd10);
    end
  end

  // strtol-style digit acceptance
  always_comb begin
    tk_take = 1'b0;
    tk_acc  = 1'b0;
    tk_neg  = negative_flag;
    tk_nsub = nsub;
    tk_rx   = radix;
    unique case (nsub)
      fpr_pkg::NS_WS, fpr_pkg::NS_SIGN: begin
        if (nsub == fpr_pkg::NS_WS && is_ws) begin
          tk_take = 1'b1;
        end else if (nsub == fpr_pkg::NS_WS && is_sign) begin
          tk_take = 1'b1;
          tk_neg  = (in_byte == fpr_pkg::CH_MINUS);
          tk_nsub = fpr_pkg::NS_SIGN;
        end else if (in_byte == fpr_pkg::CH_ZERO) begin
          tk_take = 1'b1;
          tk_nsub = fpr_pkg::NS_ZERO;
        end else if (is_nz_dec) begin
          tk_take = 1'b1;
          tk_acc  = 1'b1;
          tk_rx   = fpr_pkg::RX_DEC;
          tk_nsub = fpr_pkg::NS_DIGITS;
        end
      end
      fpr_pkg::NS_ZERO: begin
        if (in_byte == fpr_pkg::CH_LX || in_byte == fpr_pkg::CH_UX) begin
          tk_take = 1'b1;
          tk_nsub = fpr_pkg::NS_HEXPFX;
        end else if (is_oct) begin
          tk_take = 1'b1;
          tk_acc  = 1'b1;
          tk_rx   = fpr_pkg::RX_OCT;
          tk_nsub = fpr_pkg::NS_DIGITS;
        end
      end
      fpr_pkg::NS_HEXPFX: begin
        if (is_hex) begin
          tk_take = 1'b1;
          tk_acc  = 1'b1;
          tk_rx   = fpr_pkg::RX_HEX;
          tk_nsub = fpr_pkg::NS_DIGITS;
        end
      end
      default: begin
        if ((radix == fpr_pkg::RX_HEX && is_hex) ||
            (radix == fpr_pkg::RX_OCT && is_oct) ||
            (radix == fpr_pkg::RX_DEC && is_dec)) begin
          tk_take = 1'b1;
          tk_acc  = 1'b1;
        end
      end
    endcase
  end

  // magnitude * base + digit, overflow when the sum passes 2^63
  always_comb begin
    case (tk_rx)
      fpr_pkg::RX_HEX: acc_scaled = {4'b0, magnitude} << 4;
      fpr_pkg::RX_OCT: acc_scaled = {4'b0, magnitude} << 3;
      default:         acc_scaled = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1);
    endcase
    acc_sum = acc_scaled + {64'b0, dval};
    acc_ovf = acc_sum > fpr_pkg::LIM63;
    if (!tk_acc || overflow_flag) begin
      acc_mag     = magnitude;
      acc_ovf_out = overflow_flag;
    end else if (acc_ovf) begin
      acc_mag     = magnitude;
      acc_ovf_out = 1'b1;
    end else begin
      acc_mag     = acc_sum[63:0];
      acc_ovf_out = 1'b0;
    end
  end

  always_comb begin
    saturated = overflow_flag || (!negative_flag && magnitude[63]);
    is_code   = !saturated && !(negative_flag && magnitude != 64'd0) &&
                (magnitude == {54'd0, pasv_code});
    if (saturated) begin
      low_byte = negative_flag ? 8'h00 : 8'hFF;
    end else if (negative_flag) begin
      low_byte = 8'h00 - magnitude[7:0];
    end else begin
      low_byte = magnitude[7:0];
    end
  end

  always_comb begin
    nsub_next          = nsub;
    radix_next         = radix;
    negative_flag_next = negative_flag;
    magnitude_next     = magnitude;
    overflow_flag_next = overflow_flag;
    field_index_next   = field_index;
    address_acc_next   = address_acc;
    port_acc_next      = port_acc;
    byte_count_next    = byte_count;
    srch               = 1'b0;

    // port decision on the first byte of a segment
    if (byte_count == '0) begin
      port_latch_next = in_port;
      ph = (in_port != control_port) ? fpr_pkg::PH_STOPPED : phase;
    end else begin
      port_latch_next = port_latch;
      ph = phase;
    end

    if (byte_count < fpr_pkg::BYTE_COUNT_W'(fpr_pkg::MAX_TEXT_BYTES)) begin
      byte_count_next = byte_count + fpr_pkg::BYTE_COUNT_W'(1);
      if (ph != fpr_pkg::PH_STOPPED && ph != fpr_pkg::PH_FOUND) begin
        if (in_byte == fpr_pkg::CH_NUL) begin
          ph = fpr_pkg::PH_STOPPED;
        end else begin
          srch = 1'b1;
          if ((ph == fpr_pkg::PH_STATUS || ph == fpr_pkg::PH_FIELD) && tk_take) begin
            srch               = 1'b0;
            nsub_next          = tk_nsub;
            radix_next         = tk_rx;
            negative_flag_next = tk_neg;
            magnitude_next     = acc_mag;
            overflow_flag_next = acc_ovf_out;
          end else if (ph == fpr_pkg::PH_STATUS) begin
            if (!is_code) begin
              ph   = fpr_pkg::PH_STOPPED;
              srch = 1'b0;
            end else begin
              ph = fpr_pkg::PH_SEEK_OPEN;
            end
          end else if (ph == fpr_pkg::PH_FIELD) begin
            case (field_index)
              3'd0:    address_acc_next[31:24] = address_acc[31:24] | low_byte;
              3'd1:    address_acc_next[23:16] = address_acc[23:16] | low_byte;
              3'd2:    address_acc_next[15:8]  = address_acc[15:8]  | low_byte;
              3'd3:    address_acc_next[7:0]   = address_acc[7:0]   | low_byte;
              3'd4:    port_acc_next[15:8]     = port_acc[15:8]     | low_byte;
              default: port_acc_next[7:0]      = port_acc[7:0]      | low_byte;
            endcase
            ph = (field_index < 3'd5) ? fpr_pkg::PH_SEEK_COMMA : fpr_pkg::PH_SEEK_CLOSE;
          end

          if (srch) begin
            if ((ph == fpr_pkg::PH_SEEK_OPEN && in_byte == fpr_pkg::CH_OPEN) ||
                (ph == fpr_pkg::PH_SEEK_COMMA && in_byte == fpr_pkg::CH_COMMA)) begin
              field_index_next   = (ph == fpr_pkg::PH_SEEK_OPEN) ? 3'd0 : field_index + 3'd1;
              nsub_next          = fpr_pkg::NS_WS;
              radix_next         = fpr_pkg::RX_DEC;
              negative_flag_next = 1'b0;
              magnitude_next     = 64'd0;
              overflow_flag_next = 1'b0;
              ph                 = fpr_pkg::PH_FIELD;
            end else if (ph == fpr_pkg::PH_SEEK_CLOSE && in_byte == fpr_pkg::CH_CLOSE) begin
              ph = fpr_pkg::PH_FOUND;
            end
          end
        end
      end
    end
    phase_next = ph;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_port <= fpr_pkg::CONTROL_PORT_RST;
      pasv_code    <= fpr_pkg::PASV_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpr_pkg::CFG_CONTROL_PORT: control_port <= cfg_data;
        fpr_pkg::CFG_PASV_CODE:    pasv_code    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata[7:0];
      in_port <= s_axis_tdata[23:8];
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && in_last)) begin
      // reset or a segment end: back to the start-of-segment state
      phase         <= fpr_pkg::PH_STATUS;
      nsub          <= fpr_pkg::NS_WS;
      radix         <= fpr_pkg::RX_DEC;
      field_index   <= 3'd0;
      negative_flag <= 1'b0;
      magnitude     <= 64'd0;
      overflow_flag <= 1'b0;
      byte_count    <= '0;
      address_acc   <= 32'd0;
      port_acc      <= 16'd0;
      port_latch    <= 16'd0;
    end else if (advance) begin
      phase         <= phase_next;
      nsub          <= nsub_next;
      radix         <= radix_next;
      field_index   <= field_index_next;
      negative_flag <= negative_flag_next;
      magnitude     <= magnitude_next;
      overflow_flag <= overflow_flag_next;
      byte_count    <= byte_count_next;
      address_acc   <= address_acc_next;
      port_acc      <= port_acc_next;
      port_latch    <= port_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_found   <= (phase_next == fpr_pkg::PH_FOUND);
      out_address <= (phase_next == fpr_pkg::PH_FOUND) ? address_acc_next : 32'd0;
      out_port    <= (phase_next == fpr_pkg::PH_FOUND) ? port_acc_next : port_latch_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_port, out_address, out_found};

  // no-match result carries a zero address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_found) |-> (out_address == 32'd0))
    else $error("address not zero on a no-match result");

  assert property (@(posedge clk) disable iff (rst)
    byte_count <= fpr_pkg::BYTE_COUNT_W'(fpr_pkg::MAX_TEXT_BYTES))
    else $error("byte count past text limit");

  assert property (@(posedge clk) disable iff (rst)
    (advance && in_last) |=> (byte_count == '0 && phase == fpr_pkg::PH_STATUS))
    else $error("parse state not cleared after final byte");

  assert property (@(posedge clk) disable iff (rst)
    (phase == fpr_pkg::PH_FOUND || phase == fpr_pkg::PH_SEEK_CLOSE) |-> (field_index == 3'd5))
    else $error("closing phase reached before sixth field");

  // a held result is not overwritten by a new final byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !(advance && in_last))
    else $error("result overwritten while stalled");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for ftp_pasv_reply_parser_unit
// streams payload segments, predicts each passive reply and compares every result
// depends on fpr_pkg and the parser rtl
`timescale 1ns / 1ps

module tb_top;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic        found;
    logic [31:0] address;
    logic [15:0] data_port;
  } pasv_reply_t;

  localparam logic [63:0] SAT_LIMIT = 64'h8000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [fpr_pkg::IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tlast;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [fpr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_we;
  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fpr_pkg::CFG_DATA_W-1:0] cfg_data;

  always #1 clk = ~clk;

  ftp_pasv_reply_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  pasv_reply_t reply_q[$];
  int fail_count = 0;

  // settings as the stimulus side sees them
  logic [15:0] tgt_control_port = fpr_pkg::CONTROL_PORT_RST;
  logic [9:0]  tgt_pasv_code    = fpr_pkg::PASV_CODE_RST;

  int tx_burst_left = 0;
  bit tx_steady = 1'b0;
  int hold_seq = 0;
  int hold_len = 0;

  // ---------------------------------------------------------------------------
  // reply predictor
  // ---------------------------------------------------------------------------
  logic [15:0]         reg_control_port;
  logic [9:0]          reg_pasv_code;
  fpr_pkg::phase_t     ps_phase;
  logic [2:0]          ps_field;
  fpr_pkg::num_state_t ps_nstate;
  fpr_pkg::radix_t     ps_radix;
  logic                ps_neg;
  logic [63:0]         ps_mag;
  logic                ps_ovf;
  int                  ps_count;
  logic [31:0]         ps_addr;
  logic [15:0]         ps_port;
  logic [15:0]         ps_latch;
  logic                ps_started;

  function automatic void pasv_start_number();
    ps_nstate = fpr_pkg::NS_WS;
    ps_radix  = fpr_pkg::RX_DEC;
    ps_neg    = 1'b0;
    ps_mag    = '0;
    ps_ovf    = 1'b0;
  endfunction

  function automatic void pasv_clear_segment();
    pasv_start_number();
    ps_phase   = fpr_pkg::PH_STATUS;
    ps_field   = '0;
    ps_count   = 0;
    ps_addr    = '0;
    ps_port    = '0;
    ps_latch   = '0;
    ps_started = 1'b0;
  endfunction

  function automatic int unsigned char_digit(logic [7:0] c);
    if (c >= fpr_pkg::CH_ZERO && c <= fpr_pkg::CH_NINE) return c - fpr_pkg::CH_ZERO;
    if (c >= fpr_pkg::CH_LA && c <= fpr_pkg::CH_LF) return c - fpr_pkg::CH_LA + 10;
    if (c >= fpr_pkg::CH_UA && c <= fpr_pkg::CH_UF) return c - fpr_pkg::CH_UA + 10;
    return 99;
  endfunction

  function automatic void pasv_accumulate(logic [63:0] d);
    logic [63:0] base;
    base = (ps_radix == fpr_pkg::RX_HEX) ? 64'd16 :
           (ps_radix == fpr_pkg::RX_OCT) ? 64'd8 : 64'd10;
    if (!ps_ovf) begin
      if (ps_mag > (SAT_LIMIT - d) / base) ps_ovf = 1'b1;
      else ps_mag = ps_mag * base + d;
    end
  endfunction

  // 1 when the byte belongs to the number, 0 when it ends it
  function automatic bit pasv_number_take(logic [7:0] c);
    int unsigned d;
    int unsigned lim;
    d = char_digit(c);
    if (ps_nstate == fpr_pkg::NS_WS) begin
      if (c == fpr_pkg::CH_SPACE || (c >= fpr_pkg::CH_TAB && c <= fpr_pkg::CH_CR)) return 1'b1;
      if (c == fpr_pkg::CH_PLUS || c == fpr_pkg::CH_MINUS) begin
        ps_neg = (c == fpr_pkg::CH_MINUS);
        ps_nstate = fpr_pkg::NS_SIGN;
        return 1'b1;
      end
    end
    case (ps_nstate)
      fpr_pkg::NS_WS, fpr_pkg::NS_SIGN: begin
        if (c == fpr_pkg::CH_ZERO) begin
          ps_nstate = fpr_pkg::NS_ZERO;
          return 1'b1;
        end
        if (c >= fpr_pkg::CH_ONE && c <= fpr_pkg::CH_NINE) begin
          ps_radix = fpr_pkg::RX_DEC;
          ps_nstate = fpr_pkg::NS_DIGITS;
          pasv_accumulate(64'(d));
          return 1'b1;
        end
      end
      fpr_pkg::NS_ZERO: begin
        if (c == fpr_pkg::CH_LX || c == fpr_pkg::CH_UX) begin
          ps_nstate = fpr_pkg::NS_HEXPFX;
          return 1'b1;
        end
        if (c >= fpr_pkg::CH_ZERO && c <= fpr_pkg::CH_SEVEN) begin
          ps_radix = fpr_pkg::RX_OCT;
          ps_nstate = fpr_pkg::NS_DIGITS;
          pasv_accumulate(64'(d));
          return 1'b1;
        end
      end
      fpr_pkg::NS_HEXPFX: begin
        if (d < 16) begin
          ps_radix = fpr_pkg::RX_HEX;
          ps_nstate = fpr_pkg::NS_DIGITS;
          pasv_accumulate(64'(d));
          return 1'b1;
        end
      end
      default: begin
        lim = (ps_radix == fpr_pkg::RX_HEX) ? 16 : (ps_radix == fpr_pkg::RX_OCT) ? 8 : 10;
        if (d < lim) begin
          pasv_accumulate(64'(d));
          return 1'b1;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic bit pasv_saturated();
    return ps_ovf || (!ps_neg && ps_mag >= SAT_LIMIT);
  endfunction

  function automatic logic [7:0] pasv_low_byte();
    logic [63:0] twos;
    if (pasv_saturated()) return ps_neg ? 8'h00 : 8'hFF;
    twos = 64'd0 - ps_mag;
    return ps_neg ? twos[7:0] : ps_mag[7:0];
  endfunction

  function automatic bit pasv_is_code();
    if (pasv_saturated()) return 1'b0;
    if (ps_neg && ps_mag != 0) return 1'b0;
    return ps_mag == {54'd0, reg_pasv_code};
  endfunction

  function automatic void pasv_search_byte(logic [7:0] c);
    if (ps_phase == fpr_pkg::PH_SEEK_OPEN && c == fpr_pkg::CH_OPEN) begin
      ps_field = '0;
      pasv_start_number();
      ps_phase = fpr_pkg::PH_FIELD;
    end else if (ps_phase == fpr_pkg::PH_SEEK_COMMA && c == fpr_pkg::CH_COMMA) begin
      ps_field = ps_field + 3'd1;
      pasv_start_number();
      ps_phase = fpr_pkg::PH_FIELD;
    end else if (ps_phase == fpr_pkg::PH_SEEK_CLOSE && c == fpr_pkg::CH_CLOSE) begin
      ps_phase = fpr_pkg::PH_FOUND;
    end
  endfunction

  function automatic void pasv_text_byte(logic [7:0] c);
    logic [7:0] b;
    int sh;
    if (c == fpr_pkg::CH_NUL) begin
      ps_phase = fpr_pkg::PH_STOPPED;
      return;
    end
    if (ps_phase == fpr_pkg::PH_STATUS) begin
      if (pasv_number_take(c)) return;
      if (!pasv_is_code()) begin
        ps_phase = fpr_pkg::PH_STOPPED;
        return;
      end
      ps_phase = fpr_pkg::PH_SEEK_OPEN;
    end else if (ps_phase == fpr_pkg::PH_FIELD) begin
      if (pasv_number_take(c)) return;
      b = pasv_low_byte();
      sh = 24 - 8 * int'(ps_field);
      if (ps_field < 3'd4) ps_addr = ps_addr | ({24'd0, b} << sh);
      else if (ps_field == 3'd4) ps_port = ps_port | {b, 8'd0};
      else ps_port = ps_port | {8'd0, b};
      ps_phase = (ps_field < 3'd5) ? fpr_pkg::PH_SEEK_COMMA : fpr_pkg::PH_SEEK_CLOSE;
    end
    // the byte that ended a number may also be the delimiter
    pasv_search_byte(c);
  endfunction

  function automatic void pasv_predict_byte(logic [7:0] c, logic last, logic [15:0] port);
    pasv_reply_t r;
    if (!ps_started) begin
      ps_started = 1'b1;
      ps_latch = port;
      if (ps_latch != reg_control_port) ps_phase = fpr_pkg::PH_STOPPED;
    end
    if (ps_count < fpr_pkg::MAX_TEXT_BYTES) begin
      ps_count++;
      if (ps_phase != fpr_pkg::PH_STOPPED && ps_phase != fpr_pkg::PH_FOUND) pasv_text_byte(c);
    end
    if (last) begin
      if (ps_phase == fpr_pkg::PH_FOUND)
        r = '{found: 1'b1, address: ps_addr, data_port: ps_port};
      else r = '{found: 1'b0, address: 32'd0, data_port: ps_latch};
      reply_q.push_back(r);
      pasv_clear_segment();
    end
  endfunction

  // results are checked before the byte of the same edge is predicted
  always @(posedge clk) begin
    pasv_reply_t want;
    if (rst) begin
      reg_control_port = fpr_pkg::CONTROL_PORT_RST;
      reg_pasv_code = fpr_pkg::PASV_CODE_RST;
      pasv_clear_segment();
      reply_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          $error("result with no reply pending: tdata %h", m_axis_tdata);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (m_axis_tdata[0] !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[32:1] !== want.address) begin
            $error("pasv_address: expected %h, actual %h", want.address, m_axis_tdata[32:1]);
            fail_count++;
          end
          if (m_axis_tdata[48:33] !== want.data_port) begin
            $error("data_port: expected %0d, actual %0d", want.data_port, m_axis_tdata[48:33]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pasv_predict_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[23:8]);
      if (cfg_we) begin
        if (cfg_index == fpr_pkg::CFG_CONTROL_PORT) reg_control_port = cfg_data;
        else if (cfg_index == fpr_pkg::CFG_PASV_CODE) reg_pasv_code = cfg_data[9:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: own stall pattern plus an on-demand long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int rx_mode;
    int rx_left;
    int rx_hold;
    int rx_seen;
    int rx_tick;
    m_axis_tready = 1'b0;
    rx_mode = 0;
    rx_left = 0;
    rx_hold = 0;
    rx_seen = 0;
    rx_tick = 0;
    forever begin
      @(posedge clk);
      rx_tick++;
      if (hold_seq != rx_seen) begin
        rx_seen = hold_seq;
        rx_hold = hold_len;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ((rx_tick % 7) < 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic last, input logic [15:0] port);
    int gap;
    gap = 0;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 32);
      if (!tx_steady && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    tx_burst_left--;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {port, c};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic send_segment(input byte_q_t seg, input logic [15:0] port);
    for (int i = 0; i < seg.size(); i++) send_byte(seg[i], (i == seg.size() - 1), port);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fpr_pkg::CFG_DATA_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == fpr_pkg::CFG_CONTROL_PORT) tgt_control_port = value;
    else tgt_pasv_code = value[9:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic string ws_text();
    string pool;
    string s;
    int k;
    pool = " \t\n\v\f\r";
    s = "";
    repeat ($urandom_range(0, 2)) begin
      k = $urandom_range(0, 5);
      s = {s, pool.substr(k, k)};
    end
    return s;
  endfunction

  function automatic string status_text();
    int unsigned code;
    string t;
    code = tgt_pasv_code;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: t = $sformatf("%0d", (code + $urandom_range(1, 999)) % 1000);
        1: t = $sformatf("-%0d", code + 1);
        default: t = "PASV";
      endcase
      return t;
    end
    case ($urandom_range(0, 5))
      0: t = $sformatf("0x%0h", code);
      1: begin
        t = $sformatf("%0h", code);
        t = {"0X", t.toupper()};
      end
      2: t = $sformatf("0%0o", code);
      3: t = $sformatf("+%0d", code);
      4: begin
        if (code == 0) t = "-0";
        else t = $sformatf("%0d", code);
      end
      default: t = $sformatf("%0d", code);
    endcase
    return t;
  endfunction

  function automatic string field_text();
    int unsigned v;
    string t;
    v = $urandom_range(0, 255);
    case ($urandom_range(0, 11))
      0, 1, 2, 3: t = $sformatf("%0d", v);
      4: t = $sformatf("0x%0h", v);
      5: begin
        t = $sformatf("%0h", v);
        t = {"0X", t.toupper()};
      end
      6: t = $sformatf("0%0o", v);
      7: t = $sformatf("-%0d", $urandom_range(0, 300));
      8: t = $sformatf("%0d", $urandom());
      9: begin
        // saturation and the exact 2^63 boundary
        case ($urandom_range(0, 5))
          0: t = "99999999999999999999";
          1: t = "-99999999999999999999";
          2: t = "0xFFFFFFFFFFFFFFFF";
          3: t = "0x8000000000000000";
          4: t = "-0x8000000000000000";
          default: t = "01777777777777777777777";
        endcase
      end
      10: begin
        // numbers with no usable digits
        case ($urandom_range(0, 5))
          0: t = "";
          1: t = "0x";
          2: t = "+";
          3: t = "-";
          4: t = "09";
          default: t = "0X";
        endcase
      end
      default: begin
        t = ws_text();
        if ($urandom_range(0, 1) != 0) t = {t, "+"};
        t = {t, $sformatf("%0d", v)};
      end
    endcase
    return t;
  endfunction

  function automatic string reply_text();
    string s;
    s = {ws_text(), status_text()};
    case ($urandom_range(0, 3))
      0: ;
      1: s = {s, " "};
      2: s = {s, " Entering Passive Mode "};
      default: s = {s, " ok "};
    endcase
    s = {s, "("};
    for (int i = 0; i < 6; i++) begin
      s = {s, field_text()};
      if ($urandom_range(0, 3) == 0) s = {s, " "};
      if (i < 5) s = {s, ","};
    end
    s = {s, ")"};
    if ($urandom_range(0, 1) != 0) s = {s, ".\r\n"};
    return s;
  endfunction

  // mostly well-formed replies, some broken ones and some raw noise
  task automatic make_segment(output byte_q_t seg, output logic [15:0] port);
    int pick;
    int pos;
    pick = $urandom_range(0, 15);
    if ($urandom_range(0, 7) == 0) port = 16'($urandom());
    else port = tgt_control_port;
    if (pick == 0) begin
      seg = {};
      repeat ($urandom_range(1, 70)) seg.push_back(8'($urandom()));
    end else begin
      seg = text_bytes(reply_text());
      pos = $urandom_range(0, seg.size() - 1);
      if (pick <= 4) begin
        case ($urandom_range(0, 4))
          0: seg = seg[0:pos];
          1: seg.insert(pos, fpr_pkg::CH_NUL);
          2: if (seg.size() > 1) seg.delete(pos);
          3: seg[pos] = 8'($urandom());
          default: repeat ($urandom_range(20, 50)) seg.insert(pos, fpr_pkg::CH_SPACE);
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_replies();
    byte_q_t seg;
    string pad;
    send_segment(text_bytes("227 Entering Passive Mode (192,168,1,2,19,137).\r\n"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 Entering Passive Mode (192,168,1,2,19,137).\r\n"), 16'd20);
    send_segment(text_bytes("226 Transfer complete (1,2,3,4,5,6)"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes(" \t+0xE3(0x7f,0177,0XfF,-1,0x,+)"), fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("0343 (99999999999999999999,-99999999999999999999,1,2,3,4)"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 (9223372036854775807,-9223372036854775808,0,0,255,255)"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 (0x8000000000000000,-0x8000000000000000,-0,09,1,2)"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 (256,-256,1000,300,65535,4294967295)"),
                 fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 (1,2,3,4,5,6,7)"), fpr_pkg::CONTROL_PORT_RST);
    // zero byte ends the text before the closing paren
    seg = text_bytes("227 (1,2,3,4,5,6");
    seg.push_back(fpr_pkg::CH_NUL);
    seg.push_back(fpr_pkg::CH_CLOSE);
    send_segment(seg, fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("227 (10,20,30"), fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("-227 (1,2,3,4,5,6)"), fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes("(1,2,3,4,5,6)"), fpr_pkg::CONTROL_PORT_RST);
    // closing paren on the last byte inside the window, then one byte past it
    pad = "";
    repeat (47) pad = {pad, " "};
    send_segment(text_bytes({"227", pad, "(1,2,3,4,5,6)"}), fpr_pkg::CONTROL_PORT_RST);
    send_segment(text_bytes({"227", pad, " (1,2,3,4,5,6)).\r\n"}), fpr_pkg::CONTROL_PORT_RST);
    seg = '{8'hFF};
    send_segment(seg, fpr_pkg::CONTROL_PORT_RST);
    seg = '{fpr_pkg::CH_NUL};
    send_segment(seg, 16'hFFFF);
    send_segment(text_bytes("2"), fpr_pkg::CONTROL_PORT_RST);
  endtask

  task automatic test_register_extremes();
    write_reg(fpr_pkg::CFG_CONTROL_PORT, 16'hFFFF);
    write_reg(fpr_pkg::CFG_PASV_CODE, 16'd999);
    send_segment(text_bytes("999 (1,2,3,4,5,6)"), 16'hFFFF);
    send_segment(text_bytes("0x3E7(255,0,255,0,255,0)"), 16'hFFFF);
    send_segment(text_bytes("999 (1,2,3,4,5,6)"), 16'h0000);
    write_reg(fpr_pkg::CFG_CONTROL_PORT, 16'h0000);
    write_reg(fpr_pkg::CFG_PASV_CODE, 16'd0);
    send_segment(text_bytes("-0 (1,2,3,4,5,6)"), 16'h0000);
    // a status with no digits reads as zero
    send_segment(text_bytes("PASV(10,0,0,1,4,1)"), 16'h0000);
    send_segment(text_bytes("0x(1,2,3,4,5,6)"), 16'h0000);
    send_segment(text_bytes("227 (1,2,3,4,5,6)"), 16'h0000);
    write_reg(fpr_pkg::CFG_CONTROL_PORT, fpr_pkg::CONTROL_PORT_RST);
    write_reg(fpr_pkg::CFG_PASV_CODE, 16'(fpr_pkg::PASV_CODE_RST));
  endtask

  // result side holds off while short segments keep coming
  task automatic test_output_hold();
    byte_q_t seg;
    wait_idle();
    hold_len = 400;
    hold_seq++;
    tx_steady = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 3) == 0) begin
        seg = text_bytes("227(1,2,3,4,5,6)");
      end else begin
        seg = {};
        repeat ($urandom_range(1, 3)) seg.push_back(8'($urandom()));
      end
      send_segment(seg, tgt_control_port);
    end
    tx_steady = 1'b0;
  endtask

  task automatic test_random_replies();
    byte_q_t seg;
    logic [15:0] port;
    int phase_bytes;
    int total;
    int ph;
    total = 0;
    ph = 0;
    while (total < 350) begin
      case (ph)
        0: begin
          write_reg(fpr_pkg::CFG_CONTROL_PORT, fpr_pkg::CONTROL_PORT_RST);
          write_reg(fpr_pkg::CFG_PASV_CODE, 16'(fpr_pkg::PASV_CODE_RST));
        end
        1: begin
          write_reg(fpr_pkg::CFG_CONTROL_PORT, 16'h0000);
          write_reg(fpr_pkg::CFG_PASV_CODE, 16'd0);
        end
        2: begin
          write_reg(fpr_pkg::CFG_CONTROL_PORT, 16'hFFFF);
          write_reg(fpr_pkg::CFG_PASV_CODE, 16'd999);
        end
        default: begin
          write_reg(fpr_pkg::CFG_CONTROL_PORT, 16'($urandom()));
          write_reg(fpr_pkg::CFG_PASV_CODE, 16'($urandom_range(0, 999)));
        end
      endcase
      tx_steady = (ph % 3 == 2);
      phase_bytes = 0;
      while (phase_bytes < 90 && total < 350) begin
        make_segment(seg, port);
        send_segment(seg, port);
        phase_bytes += seg.size();
        total += seg.size();
      end
      ph++;
    end
    tx_steady = 1'b0;
  endtask

  initial begin
    int drain;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_directed_replies();
    test_register_extremes();
    test_output_hold();
    test_random_replies();

    s_axis_tvalid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (reply_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (reply_q.size() != 0) begin
      $error("%0d expected replies never arrived", reply_q.size());
      fail_count++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
